// ----- hdl/svoice_pkg.sv -----
// Shared types and constants for the synthesizer voice allocator.
// Used by svoice_cell and synth_voice_allocator; depends on nothing.

package svoice_pkg;

    localparam int VOICE_COUNT = 18;
    localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_CONTROL  = 2'd2;
    localparam logic [1:0] REQ_PROGRAM  = 2'd3;

    localparam logic [6:0] CTRL_VOLUME    = 7'd11;
    localparam logic [6:0] CTRL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CTRL_NOTES_OFF = 7'd123;

    localparam logic [3:0] PERC_CH     = 4'd9;
    localparam logic [6:0] PERC_NOTE   = 7'd60;
    localparam logic [4:0] CH_FREE     = 5'd31;
    localparam logic [7:0] NOTE_NONE   = 8'hFF;
    localparam logic [8:0] TIMBRE_NONE = 9'h1FF;
    localparam logic [15:0] PRIO_FREED = 16'hFFFF;
    localparam logic [6:0] VOLUME_MAX  = 7'd127;

    localparam logic ACT_KEY_OFF = 1'b0;
    localparam logic ACT_KEY_ON  = 1'b1;

    typedef struct packed {
        logic [4:0]  ch;
        logic [7:0]  note;
        logic [8:0]  timbre;
        logic [15:0] prio;
    } voice_t;

    localparam voice_t VOICE_RESET = '{ch: CH_FREE, note: NOTE_NONE,
                                       timbre: TIMBRE_NONE, prio: 16'd0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEAL,
        ST_APPLY,
        ST_KEYON,
        ST_RELEASE,
        ST_FLUSH
    } state_t;

endpackage

// ----- hdl/synth_voice_allocator.sv -----
// Voice allocator top level: request decode, ring sequencer and result register.
// Depends on svoice_pkg and svoice_cell.

// The voice table is a ring of VOICE_COUNT cells that rotates one place per
// cycle past a single evaluation point while a pass runs; a release pass
// pauses while a result waits. A note-on makes one full rotation to search
// for the note, a free voice and the lowest priority, an optional key-off
// for a stolen voice, a second rotation that writes the voice and ages all
// priorities, then the key-on. Note-off and all-notes-off take one rotation
// and a flush step, longer if results are not taken; every key-off found
// waits in a holding register so that the final one can carry last. Volume
// and program changes finish in the cycle they are accepted. A new request
// is taken only when the previous one is finished; a result may still wait.

module synth_voice_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [3:0] midi_channel,
    input  logic [6:0] key,
    input  logic [6:0] amount,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       action,
    output logic [4:0] voice_index,
    output logic [7:0] timbre,
    output logic       reload_timbre,
    output logic [6:0] play_note,
    output logic [6:0] level,
    output logic       last
);

    localparam int N = svoice_pkg::VOICE_COUNT;
    localparam int W = svoice_pkg::VIDX_W;
    localparam logic [W-1:0] POS_LAST = W'(N - 1);

    svoice_pkg::voice_t cell_q [N];
    svoice_pkg::voice_t tail_d;
    svoice_pkg::voice_t head;
    logic shift;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            svoice_pkg::voice_t d_in;
            if (gi == N - 1)
            begin : g_tail
                assign d_in = tail_d;
            end
            else
            begin : g_mid
                assign d_in = cell_q[gi + 1];
            end
            svoice_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (d_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    svoice_pkg::state_t state_reg, state_next;
    logic [W-1:0]  pos_reg, pos_next;
    logic [3:0]    ch_reg, ch_next;
    logic [6:0]    key_reg, key_next;
    logic          all_off_reg, all_off_next;
    logic [13:0]   prod_reg, prod_next;
    logic          hit_reg, hit_next;
    logic [W-1:0]  hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic          match_reg, match_next;
    logic [W-1:0]  free_idx_reg, free_idx_next;
    logic [W-1:0]  low_idx_reg, low_idx_next;
    logic [15:0]   low_prio_reg, low_prio_next;
    logic [W-1:0]  sel_reg, sel_next;
    logic          reload_reg, reload_next;
    logic          pend_reg, pend_next;
    logic [W-1:0]  pend_idx_reg, pend_idx_next;
    logic [6:0]    vol_reg [16];
    logic [6:0]    prog_reg [16];

    logic          out_valid_reg, out_valid_next;
    logic          action_reg, action_next;
    logic [4:0]    vidx_reg, vidx_next;
    logic [7:0]    timbre_reg, timbre_next;
    logic          reload_out_reg, reload_out_next;
    logic [6:0]    note_reg, note_next;
    logic [6:0]    level_reg, level_next;
    logic          last_reg, last_next;

    logic          can_load;
    logic          accept;
    logic [8:0]    instr;
    logic          head_hit;
    logic          head_chan;
    logic          rel_match;
    logic [13:0]   q_est;
    logic [13:0]   q_rem;
    logic [6:0]    lvl;
    logic          pass_end;
    svoice_pkg::voice_t t;

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == svoice_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign pass_end = (pos_reg == POS_LAST);

    assign instr = (ch_reg == svoice_pkg::PERC_CH) ? {2'b01, key_reg}
                                                   : {2'b00, prog_reg[ch_reg]};
    assign head_chan = (head.ch == {1'b0, ch_reg});
    assign head_hit  = head_chan && (head.note == {1'b0, key_reg});
    assign rel_match = all_off_reg ? head_chan : head_hit;

    // Division by 127: an estimate from p*129/16384 is at most one short.
    always_comb
    begin
        q_est = (prod_reg + (prod_reg >> 7)) >> 7;
        q_rem = prod_reg - ((q_est << 7) - q_est);
        if (q_rem >= 14'd127)
        begin
            lvl = 7'(q_est + 14'd1);
        end
        else
        begin
            lvl = q_est[6:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        ch_next         = ch_reg;
        key_next        = key_reg;
        all_off_next    = all_off_reg;
        prod_next       = prod_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        match_next      = match_reg;
        free_idx_next   = free_idx_reg;
        low_idx_next    = low_idx_reg;
        low_prio_next   = low_prio_reg;
        sel_next        = sel_reg;
        reload_next     = reload_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        action_next     = action_reg;
        vidx_next       = vidx_reg;
        timbre_next     = timbre_reg;
        reload_out_next = reload_out_reg;
        note_next       = note_reg;
        level_next      = level_reg;
        last_next       = last_reg;
        shift           = 1'b0;
        tail_d          = head;
        t               = head;

        unique case (state_reg)
            svoice_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next      = midi_channel;
                    key_next     = key;
                    prod_next    = 14'(amount) * 14'(vol_reg[midi_channel]);
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    match_next   = 1'b0;
                    pend_next    = 1'b0;
                    all_off_next = (req_type == svoice_pkg::REQ_CONTROL);
                    unique case (req_type)
                        svoice_pkg::REQ_NOTE_ON:  state_next = svoice_pkg::ST_SCAN;
                        svoice_pkg::REQ_NOTE_OFF: state_next = svoice_pkg::ST_RELEASE;
                        svoice_pkg::REQ_CONTROL:
                        begin
                            if (key == svoice_pkg::CTRL_SOUND_OFF ||
                                key == svoice_pkg::CTRL_NOTES_OFF)
                            begin
                                state_next = svoice_pkg::ST_RELEASE;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            svoice_pkg::ST_SCAN:
            begin
                shift = 1'b1;
                if (head_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pos_reg;
                end
                if (head.ch == svoice_pkg::CH_FREE && !match_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = pos_reg;
                    if (head.timbre == instr)
                    begin
                        match_next = 1'b1;
                    end
                end
                if (pos_reg == '0 || head.prio < low_prio_reg)
                begin
                    low_idx_next  = pos_reg;
                    low_prio_next = head.prio;
                end
                pos_next = pass_end ? '0 : pos_reg + 1'b1;
                if (pass_end)
                begin
                    if (hit_next)
                    begin
                        sel_next   = hit_idx_next;
                        state_next = svoice_pkg::ST_APPLY;
                    end
                    else if (free_next)
                    begin
                        sel_next   = free_idx_next;
                        state_next = svoice_pkg::ST_APPLY;
                    end
                    else
                    begin
                        sel_next   = low_idx_next;
                        state_next = svoice_pkg::ST_STEAL;
                    end
                end
            end

            svoice_pkg::ST_STEAL:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    action_next     = svoice_pkg::ACT_KEY_OFF;
                    vidx_next       = 5'(sel_reg);
                    timbre_next     = '0;
                    reload_out_next = 1'b0;
                    note_next       = '0;
                    level_next      = '0;
                    last_next       = 1'b0;
                    state_next      = svoice_pkg::ST_APPLY;
                end
            end

            svoice_pkg::ST_APPLY:
            begin
                shift = 1'b1;
                if (pos_reg == sel_reg)
                begin
                    reload_next = (head.timbre != instr);
                    t.ch     = {1'b0, ch_reg};
                    t.note   = {1'b0, key_reg};
                    t.timbre = instr;
                    t.prio   = {3'b000, 5'(5'd16 - {1'b0, ch_reg}), 8'hFF};
                end
                if (t.prio != '0)
                begin
                    t.prio = t.prio - 16'd1;
                end
                tail_d   = t;
                pos_next = pass_end ? '0 : pos_reg + 1'b1;
                if (pass_end)
                begin
                    state_next = svoice_pkg::ST_KEYON;
                end
            end

            svoice_pkg::ST_KEYON:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    action_next     = svoice_pkg::ACT_KEY_ON;
                    vidx_next       = 5'(sel_reg);
                    timbre_next     = instr[7:0];
                    reload_out_next = reload_reg;
                    note_next       = (ch_reg == svoice_pkg::PERC_CH) ?
                                      svoice_pkg::PERC_NOTE : key_reg;
                    level_next      = lvl;
                    last_next       = 1'b1;
                    state_next      = svoice_pkg::ST_IDLE;
                end
            end

            svoice_pkg::ST_RELEASE:
            begin
                // A found voice is held back until the next one shows up,
                // so that the final key-off of the request can be marked.
                shift = !(rel_match && pend_reg && !can_load);
                if (shift)
                begin
                    if (rel_match)
                    begin
                        t.ch   = svoice_pkg::CH_FREE;
                        t.note = svoice_pkg::NOTE_NONE;
                        t.prio = svoice_pkg::PRIO_FREED;
                        if (pend_reg)
                        begin
                            out_valid_next  = 1'b1;
                            action_next     = svoice_pkg::ACT_KEY_OFF;
                            vidx_next       = 5'(pend_idx_reg);
                            timbre_next     = '0;
                            reload_out_next = 1'b0;
                            note_next       = '0;
                            level_next      = '0;
                            last_next       = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_idx_next = pos_reg;
                    end
                    tail_d   = t;
                    pos_next = pass_end ? '0 : pos_reg + 1'b1;
                    if (pass_end)
                    begin
                        state_next = svoice_pkg::ST_FLUSH;
                    end
                end
            end

            svoice_pkg::ST_FLUSH:
            begin
                if (!pend_reg)
                begin
                    state_next = svoice_pkg::ST_IDLE;
                end
                else if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    action_next     = svoice_pkg::ACT_KEY_OFF;
                    vidx_next       = 5'(pend_idx_reg);
                    timbre_next     = '0;
                    reload_out_next = 1'b0;
                    note_next       = '0;
                    level_next      = '0;
                    last_next       = 1'b1;
                    pend_next       = 1'b0;
                    state_next      = svoice_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = svoice_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svoice_pkg::ST_IDLE;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                vol_reg[i]  <= svoice_pkg::VOLUME_MAX;
                prog_reg[i] <= 7'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (accept && req_type == svoice_pkg::REQ_CONTROL &&
                key == svoice_pkg::CTRL_VOLUME)
            begin
                vol_reg[midi_channel] <= amount;
            end
            if (accept && req_type == svoice_pkg::REQ_PROGRAM &&
                midi_channel != svoice_pkg::PERC_CH)
            begin
                prog_reg[midi_channel] <= key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        key_reg        <= key_next;
        all_off_reg    <= all_off_next;
        prod_reg       <= prod_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        free_reg       <= free_next;
        match_reg      <= match_next;
        free_idx_reg   <= free_idx_next;
        low_idx_reg    <= low_idx_next;
        low_prio_reg   <= low_prio_next;
        sel_reg        <= sel_next;
        reload_reg     <= reload_next;
        pend_idx_reg   <= pend_idx_next;
        action_reg     <= action_next;
        vidx_reg       <= vidx_next;
        timbre_reg     <= timbre_next;
        reload_out_reg <= reload_out_next;
        note_reg       <= note_next;
        level_reg      <= level_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign voice_index   = vidx_reg;
    assign timbre        = timbre_reg;
    assign reload_timbre = reload_out_reg;
    assign play_note     = note_reg;
    assign level         = level_reg;
    assign last          = last_reg;

endmodule

// ----- hdl/svoice_cell.sv -----
// One voice slot of the rotating voice ring.
// Depends on svoice_pkg for the voice record type and its reset value.

module svoice_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  svoice_pkg::voice_t  d,
    output svoice_pkg::voice_t  q
);

    svoice_pkg::voice_t voice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= svoice_pkg::VOICE_RESET;
        end
        else if (shift)
        begin
            voice_reg <= d;
        end
    end

    assign q = voice_reg;

endmodule

// ----- dv/synth_voice_allocator_tb.sv -----
// Self-checking testbench for synth_voice_allocator: drives MIDI requests and
// checks every key-on/key-off result against an internal voice-table predictor.
// Depends on svoice_pkg and the synth_voice_allocator RTL.

module synth_voice_allocator_tb;

    typedef struct packed {
        logic [1:0] rtype;
        logic [3:0] ch;
        logic [6:0] k;
        logic [6:0] amt;
    } midi_req_t;

    typedef struct packed {
        logic       act;
        logic [4:0] vidx;
        logic [7:0] tim;
        logic       rel;
        logic [6:0] note;
        logic [6:0] lvl;
        logic       fin;
    } voice_evt_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] req_type;
    logic [3:0] midi_channel;
    logic [6:0] key;
    logic [6:0] amount;
    logic       out_valid;
    logic       out_ready;
    logic       action;
    logic [4:0] voice_index;
    logic [7:0] timbre;
    logic       reload_timbre;
    logic [6:0] play_note;
    logic [6:0] level;
    logic       last;

    synth_voice_allocator uut (.*);

    // Predictor state.
    logic [4:0]  pv_ch [svoice_pkg::VOICE_COUNT];
    logic [7:0]  pv_note [svoice_pkg::VOICE_COUNT];
    logic [8:0]  pv_tim [svoice_pkg::VOICE_COUNT];
    logic [15:0] pv_prio [svoice_pkg::VOICE_COUNT];
    logic        map_ok [2048];
    logic [4:0]  map_vox [2048];
    logic [6:0]  ch_vol [16];
    logic [6:0]  ch_prog [16];

    midi_req_t  pending_reqs[$];
    voice_evt_t expected_evts[$];
    int         errors = 0;
    bit         stim_done = 0;
    bit         hold_sender = 0;
    bit         in_taken = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void predictor_reset();
        for (int i = 0; i < svoice_pkg::VOICE_COUNT; i++)
        begin
            pv_ch[i] = svoice_pkg::CH_FREE;
            pv_note[i] = svoice_pkg::NOTE_NONE;
            pv_tim[i] = svoice_pkg::TIMBRE_NONE;
            pv_prio[i] = 16'd0;
        end
        for (int i = 0; i < 2048; i++)
        begin
            map_ok[i] = 1'b0;
            map_vox[i] = '0;
        end
        for (int i = 0; i < 16; i++)
        begin
            ch_vol[i] = svoice_pkg::VOLUME_MAX;
            ch_prog[i] = i[6:0];
        end
    endfunction

    function automatic void push_evt(ref voice_evt_t evts[$], input logic act,
                                     input int v, input logic [7:0] tim,
                                     input logic rel, input logic [6:0] note,
                                     input logic [6:0] lvl);
        voice_evt_t e;
        e = '{act, v[4:0], tim, rel, note, lvl, 1'b0};
        evts.push_back(e);
    endfunction

    function automatic void free_note(logic [3:0] c, logic [6:0] n,
                                      ref voice_evt_t evts[$]);
        int idx;
        int v;
        idx = {c, n};
        if (!map_ok[idx])
            return;
        map_ok[idx] = 1'b0;
        v = map_vox[idx];
        if (v >= svoice_pkg::VOICE_COUNT)
            return;
        push_evt(evts, svoice_pkg::ACT_KEY_OFF, v, 8'd0, 1'b0, 7'd0, 7'd0);
        pv_ch[v] = svoice_pkg::CH_FREE;
        pv_note[v] = svoice_pkg::NOTE_NONE;
        pv_prio[v] = svoice_pkg::PRIO_FREED;
    endfunction

    function automatic void predict_voice_events(midi_req_t r);
        voice_evt_t evts[$];
        logic [8:0] instr;
        int idx, v, low, lvl;
        bit found;
        logic rel;
        idx = {r.ch, r.k};
        case (r.rtype)
            svoice_pkg::REQ_NOTE_ON:
            begin
                instr = (r.ch == svoice_pkg::PERC_CH) ? {2'b01, r.k}
                                                      : {2'b00, ch_prog[r.ch]};
                v = 0;
                low = 0;
                found = 0;
                rel = 1'b0;
                if (map_ok[idx] && map_vox[idx] < svoice_pkg::VOICE_COUNT)
                    v = map_vox[idx];
                else
                begin
                    for (int x = 0; x < svoice_pkg::VOICE_COUNT; x++)
                    begin
                        if (pv_ch[x] == svoice_pkg::CH_FREE)
                        begin
                            v = x;
                            found = 1;
                            if (pv_tim[x] == instr)
                                break;
                        end
                        if (pv_prio[x] < pv_prio[low])
                            low = x;
                    end
                    if (!found)
                    begin
                        v = low;
                        free_note(pv_ch[v][3:0], pv_note[v][6:0], evts);
                    end
                end
                if (pv_tim[v] != instr)
                begin
                    pv_tim[v] = instr;
                    rel = 1'b1;
                end
                pv_ch[v] = {1'b0, r.ch};
                pv_note[v] = {1'b0, r.k};
                pv_prio[v] = {(8'd16 - r.ch), 8'hFF};
                map_ok[idx] = 1'b1;
                map_vox[idx] = v[4:0];
                lvl = (int'(r.amt) * int'(ch_vol[r.ch])) / 127;
                push_evt(evts, svoice_pkg::ACT_KEY_ON, v, instr[7:0], rel,
                         (r.ch == svoice_pkg::PERC_CH) ? svoice_pkg::PERC_NOTE : r.k,
                         lvl[6:0]);
                for (int x = 0; x < svoice_pkg::VOICE_COUNT; x++)
                    if (pv_prio[x] > 0)
                        pv_prio[x]--;
            end
            svoice_pkg::REQ_NOTE_OFF:
                free_note(r.ch, r.k, evts);
            svoice_pkg::REQ_CONTROL:
            begin
                if (r.k == svoice_pkg::CTRL_VOLUME)
                    ch_vol[r.ch] = r.amt;
                else if (r.k == svoice_pkg::CTRL_SOUND_OFF ||
                         r.k == svoice_pkg::CTRL_NOTES_OFF)
                    for (int x = 0; x < svoice_pkg::VOICE_COUNT; x++)
                        if (pv_ch[x] == {1'b0, r.ch})
                            free_note(r.ch, pv_note[x][6:0], evts);
            end
            default:
                if (r.ch != svoice_pkg::PERC_CH)
                    ch_prog[r.ch] = r.k;
        endcase
        if (evts.size() > 0)
            evts[evts.size() - 1].fin = 1'b1;
        foreach (evts[i])
            expected_evts.push_back(evts[i]);
    endfunction

    // Driver: one request at a time, random gap before each.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_voice_events('{req_type, midi_channel, key, amount});
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 3);
            end
            else if (!in_valid && !hold_sender && pending_reqs.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    midi_req_t r;
                    r = pending_reqs.pop_front();
                    req_type <= r.rtype;
                    midi_channel <= r.ch;
                    key <= r.k;
                    amount <= r.amt;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Sample the input handshake at the rising edge; the driver acts on it at
    // the falling edge, while the request fields are still unchanged.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
    end

    // Monitor.
    int recv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_evts.size() == 0)
            begin
                $error("unexpected result: voice_index %0d", voice_index);
                errors++;
            end
            else
            begin
                voice_evt_t e;
                e = expected_evts.pop_front();
                if (action !== e.act)
                begin
                    $error("action exp %0d got %0d", e.act, action);
                    errors++;
                end
                if (voice_index !== e.vidx)
                begin
                    $error("voice_index exp %0d got %0d", e.vidx, voice_index);
                    errors++;
                end
                if (timbre !== e.tim)
                begin
                    $error("timbre exp %0d got %0d", e.tim, timbre);
                    errors++;
                end
                if (reload_timbre !== e.rel)
                begin
                    $error("reload_timbre exp %0d got %0d", e.rel, reload_timbre);
                    errors++;
                end
                if (play_note !== e.note)
                begin
                    $error("play_note exp %0d got %0d", e.note, play_note);
                    errors++;
                end
                if (level !== e.lvl)
                begin
                    $error("level exp %0d got %0d", e.lvl, level);
                    errors++;
                end
                if (last !== e.fin)
                begin
                    $error("last exp %0d got %0d", e.fin, last);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            recv_gap = $urandom_range(0, 3);
            out_ready <= (recv_gap == 0);
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= (recv_gap == 0);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic midi_req_t mk(logic [1:0] t, int c, int k, int a);
        midi_req_t r;
        r = '{t, c[3:0], k[6:0], a[6:0]};
        return r;
    endfunction

    function automatic midi_req_t random_req();
        int p;
        int c;
        p = $urandom_range(0, 99);
        c = ($urandom_range(0, 3) == 0) ? 9 : $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0)
            c = $urandom_range(0, 15);
        if (p < 50)
            return mk(svoice_pkg::REQ_NOTE_ON, c, $urandom_range(36, 47) |
                      ($urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : 0),
                      $urandom_range(0, 127));
        else if (p < 80)
            return mk(svoice_pkg::REQ_NOTE_OFF, c, $urandom_range(36, 47),
                      $urandom_range(0, 127));
        else if (p < 87)
            return mk(svoice_pkg::REQ_CONTROL, c, svoice_pkg::CTRL_VOLUME,
                      $urandom_range(0, 127));
        else if (p < 91)
            return mk(svoice_pkg::REQ_CONTROL, c,
                      ($urandom_range(0, 1) ? svoice_pkg::CTRL_SOUND_OFF
                                            : svoice_pkg::CTRL_NOTES_OFF),
                      $urandom_range(0, 127));
        else if (p < 94)
            return mk(svoice_pkg::REQ_CONTROL, c, $urandom_range(0, 127),
                      $urandom_range(0, 127));
        else
            return mk(svoice_pkg::REQ_PROGRAM, c, $urandom_range(0, 127), 0);
    endfunction

    initial
    begin
        predictor_reset();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = '0;
        midi_channel = '0;
        key = '0;
        amount = '0;
        // Directed: extremes, percussion, reuse, steal, releases, ignored codes.
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 0, 0, 127));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 0, 0, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_PROGRAM, 0, 127, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 0, 0, 100));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 15, 127, 127));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 9, 35, 64));
        pending_reqs.push_back(mk(svoice_pkg::REQ_PROGRAM, 9, 5, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_CONTROL, 15, 11, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 15, 100, 127));
        pending_reqs.push_back(mk(svoice_pkg::REQ_CONTROL, 3, 7, 50));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_OFF, 2, 2, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_OFF, 0, 0, 127));
        for (int i = 0; i < 20; i++)
            pending_reqs.push_back(mk(svoice_pkg::REQ_NOTE_ON, 5, 20 + i, 90));
        pending_reqs.push_back(mk(svoice_pkg::REQ_CONTROL, 5,
                                  svoice_pkg::CTRL_NOTES_OFF, 0));
        pending_reqs.push_back(mk(svoice_pkg::REQ_CONTROL, 15,
                                  svoice_pkg::CTRL_SOUND_OFF, 0));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_reqs.size() == 0 && !in_valid);
        // Let everything drain once with the sender held off.
        hold_sender = 1'b1;
        wait (expected_evts.size() == 0);
        repeat (60) @(posedge clk);
        hold_sender = 1'b0;
        for (int i = 0; i < 300; i++)
            pending_reqs.push_back(random_req());
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_evts.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_evts.size() == 0)
            $display("Verification passed");
        else
        begin
            foreach (expected_evts[i])
                errors++;
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/svoice_pkg.sv
hdl/svoice_cell.sv
hdl/synth_voice_allocator.sv
dv/synth_voice_allocator_tb.sv
